/* hdl/hpvc_pkg.sv */
`default_nettype none

package hpvc_pkg;

    // Field widths.
    localparam int unsigned LevelW = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned CmdW   = 2;
    localparam int unsigned CfgIdxW = 3;
    // Level doubled plus the full window width fits in this many bits.
    localparam int unsigned CmpW   = LevelW + 2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_LOWER_LIMIT      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_UPPER_LIMIT      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS_WIDTH = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OPEN_TICKS       = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CLOSE_TICKS      = 3'd4;

    // Configuration reset values.
    localparam logic [CfgW-1:0] RST_LOWER_LIMIT      = 16'd200;
    localparam logic [CfgW-1:0] RST_UPPER_LIMIT      = 16'd1000;
    localparam logic [CfgW-1:0] RST_HYSTERESIS_WIDTH = 16'd100;
    localparam logic [CfgW-1:0] RST_OPEN_TICKS       = 16'd1000;
    localparam logic [CfgW-1:0] RST_CLOSE_TICKS      = 16'd2000;

    // Manual valve commands; any other code keeps the relay as it is.
    localparam logic [CmdW-1:0] CMD_OFF = 2'd0;
    localparam logic [CmdW-1:0] CMD_ON  = 2'd1;

    // Regulation state as shown on the result channel.
    typedef enum logic [1:0] {
        PH_IN_RANGE = 2'd0,
        PH_LOW      = 2'd1,
        PH_HIGH     = 2'd2
    } t_reg_phase;

    // Encoding that never appears on the result channel.
    localparam logic [1:0] PH_UNUSED = 2'd3;

endpackage

`default_nettype wire

/* hdl/hysteresis_pulsed_valve_controller_top.sv */
// Hysteresis window controller with pulsed valves, one transfer per millisecond tick.
//
// Input channel (i_in_valid / o_in_ready): each transfer carries one tick: the sensed
// level, pump and sensor fault flags, the manual mode request and the two manual
// valve commands. Result channel (o_out_valid / i_out_ready): exactly one transfer
// per input tick, giving both relay states, the regulation state and the mode.
// Configuration: i_cfg_we writes i_cfg_data into the register chosen by i_cfg_index
// (0 lower limit, 1 upper limit, 2 hysteresis width, 3 open time, 4 close time) at
// the clock edge; indexes 5 to 7 are ignored. Write only while no tick is in flight.
//
// A tick is captured in the input register, then evaluated against the controller
// state, and the outcome is loaded into the result register.
// Throughput is one tick per clock while results are taken; the only loop is the
// state update, which is a few 18-bit compares and one 16-bit decrement.
// When the receiver stalls, the result register holds its transfer, the input
// register keeps the following tick, and o_in_ready drops until the result is taken.
// Synchronous active-low reset empties both registers, puts the controller in
// automatic mode, in range, with both valves closed, and reloads the default configuration.

`default_nettype none

module hysteresis_pulsed_valve_controller_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [hpvc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  wire logic [hpvc_pkg::CfgW-1:0]         i_cfg_data,
    // Input tick channel.
    input  wire logic                              i_in_valid,
    output      logic                              o_in_ready,
    input  wire logic [hpvc_pkg::LevelW-1:0]       i_level_ppm,
    input  wire logic                              i_pump_on,
    input  wire logic                              i_sensor_fault,
    input  wire logic                              i_manual_request,
    input  wire logic [hpvc_pkg::CmdW-1:0]         i_raise_valve_cmd,
    input  wire logic [hpvc_pkg::CmdW-1:0]         i_lower_valve_cmd,
    // Result channel.
    output      logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    output      logic                              o_raise_valve_on,
    output      logic                              o_lower_valve_on,
    output      logic [1:0]                        o_regulation_state,
    output      logic                              o_manual_active
);

    // Configuration registers.
    logic [hpvc_pkg::CfgW-1:0] r_lower_limit;
    logic [hpvc_pkg::CfgW-1:0] r_upper_limit;
    logic [hpvc_pkg::CfgW-1:0] r_hyst_width;
    logic [hpvc_pkg::CfgW-1:0] r_open_ticks;
    logic [hpvc_pkg::CfgW-1:0] r_close_ticks;

    // Input register.
    logic                          r_in_valid;
    logic [hpvc_pkg::LevelW-1:0]   r_level_ppm;
    logic                          r_pump_on;
    logic                          r_sensor_fault;
    logic                          r_manual_request;
    logic [hpvc_pkg::CmdW-1:0]     r_raise_cmd;
    logic [hpvc_pkg::CmdW-1:0]     r_lower_cmd;

    // Controller state.
    logic                          r_manual_mode;
    hpvc_pkg::t_reg_phase          r_phase;
    logic                          r_valve_open;
    logic [hpvc_pkg::CfgW-1:0]     r_countdown;
    logic                          r_count_run;
    logic                          r_pulse_due;
    logic                          r_raise_relay;
    logic                          r_lower_relay;

    logic                          n_manual_mode;
    hpvc_pkg::t_reg_phase          n_phase;
    logic                          n_valve_open;
    logic [hpvc_pkg::CfgW-1:0]     n_countdown;
    logic                          n_count_run;
    logic                          n_pulse_due;
    logic                          n_raise_relay;
    logic                          n_lower_relay;

    // Result register.
    logic                          r_out_valid;
    logic                          r_out_raise;
    logic                          r_out_lower;
    logic [1:0]                    r_out_state;
    logic                          r_out_manual;

    logic in_xfer;
    logic advance;

    // A held tick moves on when the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Window compares on doubled values, so the half-width edges stay exact.
    // "level < limit - h" is tested as "level + h < limit" to keep everything unsigned.
    logic [hpvc_pkg::CmpW-1:0] lv2;
    logic [hpvc_pkg::CmpW-1:0] lv2_h;
    logic [hpvc_pkg::CmpW-1:0] l2;
    logic [hpvc_pkg::CmpW-1:0] u2;
    logic [hpvc_pkg::CmpW-1:0] l2_h;
    logic [hpvc_pkg::CmpW-1:0] u2_h;
    logic [hpvc_pkg::CmpW-1:0] hyst;
    logic                      enable_ok;
    logic                      enter_low;
    logic                      enter_high;
    logic                      exit_low;
    logic                      exit_high;

    assign hyst  = {2'b00, r_hyst_width};
    assign lv2   = {1'b0, r_level_ppm, 1'b0};
    assign l2    = {1'b0, r_lower_limit, 1'b0};
    assign u2    = {1'b0, r_upper_limit, 1'b0};
    assign lv2_h = lv2 + hyst;
    assign l2_h  = l2 + hyst;
    assign u2_h  = u2 + hyst;

    assign enable_ok  = r_pump_on && !r_sensor_fault;
    assign enter_low  = (lv2_h < l2) && enable_ok;
    assign enter_high = (lv2 > u2_h) && enable_ok;
    assign exit_low   = (lv2 > l2_h) || !enable_ok;
    assign exit_high  = (lv2_h < u2) || !enable_ok;

    always_comb begin
        n_manual_mode = r_manual_mode;
        n_phase       = r_phase;
        n_valve_open  = r_valve_open;
        n_countdown   = r_countdown;
        n_count_run   = r_count_run;
        n_pulse_due   = r_pulse_due;
        n_raise_relay = r_raise_relay;
        n_lower_relay = r_lower_relay;

        // The pulse timer runs ahead of the mode logic on every tick.
        if (r_count_run) begin
            if (r_countdown <= hpvc_pkg::CfgW'(1)) begin
                n_countdown = '0;
                n_count_run = 1'b0;
                n_pulse_due = 1'b1;
            end else begin
                n_countdown = r_countdown - hpvc_pkg::CfgW'(1);
            end
        end

        if (!r_manual_mode) begin
            // Entering manual closes everything, but the window entry tests below
            // still run on this tick.
            if (r_manual_request) begin
                n_manual_mode = 1'b1;
                n_phase       = hpvc_pkg::PH_IN_RANGE;
                n_valve_open  = 1'b0;
                n_count_run   = 1'b0;
                n_countdown   = '0;
                n_pulse_due   = 1'b0;
                n_raise_relay = 1'b0;
                n_lower_relay = 1'b0;
            end

            case (n_phase)
                hpvc_pkg::PH_LOW: begin
                    if (exit_low) begin
                        n_phase       = hpvc_pkg::PH_IN_RANGE;
                        n_valve_open  = 1'b0;
                        n_count_run   = 1'b0;
                        n_countdown   = '0;
                        n_pulse_due   = 1'b0;
                        n_raise_relay = 1'b0;
                    end else if (n_pulse_due) begin
                        n_pulse_due = 1'b0;
                        n_count_run = 1'b1;
                        if (!n_valve_open) begin
                            n_countdown   = r_open_ticks;
                            n_raise_relay = 1'b1;
                            n_valve_open  = 1'b1;
                        end else begin
                            n_countdown   = r_close_ticks;
                            n_raise_relay = 1'b0;
                            n_valve_open  = 1'b0;
                        end
                    end
                end
                hpvc_pkg::PH_HIGH: begin
                    if (exit_high) begin
                        n_phase       = hpvc_pkg::PH_IN_RANGE;
                        n_valve_open  = 1'b0;
                        n_count_run   = 1'b0;
                        n_countdown   = '0;
                        n_pulse_due   = 1'b0;
                        n_lower_relay = 1'b0;
                    end else if (n_pulse_due) begin
                        n_pulse_due = 1'b0;
                        n_count_run = 1'b1;
                        if (!n_valve_open) begin
                            n_countdown   = r_open_ticks;
                            n_lower_relay = 1'b1;
                            n_valve_open  = 1'b1;
                        end else begin
                            n_countdown   = r_close_ticks;
                            n_lower_relay = 1'b0;
                            n_valve_open  = 1'b0;
                        end
                    end
                end
                default: begin
                    // In range: high wins when both entry tests pass.
                    n_phase = hpvc_pkg::PH_IN_RANGE;
                    if (enter_low) begin
                        n_pulse_due = 1'b1;
                        n_phase     = hpvc_pkg::PH_LOW;
                    end
                    if (enter_high) begin
                        n_pulse_due = 1'b1;
                        n_phase     = hpvc_pkg::PH_HIGH;
                    end
                end
            endcase
        end else if (!r_manual_request) begin
            // Leaving manual only flips the mode; relays keep their manual values.
            n_manual_mode = 1'b0;
        end else begin
            if (r_raise_cmd == hpvc_pkg::CMD_OFF) begin
                n_raise_relay = 1'b0;
            end else if (r_raise_cmd == hpvc_pkg::CMD_ON) begin
                n_raise_relay = 1'b1;
            end
            if (r_lower_cmd == hpvc_pkg::CMD_OFF) begin
                n_lower_relay = 1'b0;
            end else if (r_lower_cmd == hpvc_pkg::CMD_ON) begin
                n_lower_relay = 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit <= hpvc_pkg::RST_LOWER_LIMIT;
            r_upper_limit <= hpvc_pkg::RST_UPPER_LIMIT;
            r_hyst_width  <= hpvc_pkg::RST_HYSTERESIS_WIDTH;
            r_open_ticks  <= hpvc_pkg::RST_OPEN_TICKS;
            r_close_ticks <= hpvc_pkg::RST_CLOSE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpvc_pkg::CFG_LOWER_LIMIT:      r_lower_limit <= i_cfg_data;
                hpvc_pkg::CFG_UPPER_LIMIT:      r_upper_limit <= i_cfg_data;
                hpvc_pkg::CFG_HYSTERESIS_WIDTH: r_hyst_width  <= i_cfg_data;
                hpvc_pkg::CFG_OPEN_TICKS:       r_open_ticks  <= i_cfg_data;
                hpvc_pkg::CFG_CLOSE_TICKS:      r_close_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: valid flag under reset, payload loaded on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_level_ppm      <= i_level_ppm;
            r_pump_on        <= i_pump_on;
            r_sensor_fault   <= i_sensor_fault;
            r_manual_request <= i_manual_request;
            r_raise_cmd      <= i_raise_valve_cmd;
            r_lower_cmd      <= i_lower_valve_cmd;
        end
    end

    // Controller state advances once per evaluated tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_mode <= 1'b0;
            r_phase       <= hpvc_pkg::PH_IN_RANGE;
            r_valve_open  <= 1'b0;
            r_countdown   <= '0;
            r_count_run   <= 1'b0;
            r_pulse_due   <= 1'b0;
            r_raise_relay <= 1'b0;
            r_lower_relay <= 1'b0;
        end else if (advance) begin
            r_manual_mode <= n_manual_mode;
            r_phase       <= n_phase;
            r_valve_open  <= n_valve_open;
            r_countdown   <= n_countdown;
            r_count_run   <= n_count_run;
            r_pulse_due   <= n_pulse_due;
            r_raise_relay <= n_raise_relay;
            r_lower_relay <= n_lower_relay;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_raise  <= n_raise_relay;
            r_out_lower  <= n_lower_relay;
            r_out_state  <= n_phase;
            r_out_manual <= n_manual_mode;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_raise_valve_on   = r_out_raise;
    assign o_lower_valve_on   = r_out_lower;
    assign o_regulation_state = r_out_state;
    assign o_manual_active    = r_out_manual;

endmodule

`default_nettype wire

/* hdl/hpvc_checker.sv */
`default_nettype none

module hpvc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         o_raise_valve_on,
    input wire logic                         o_lower_valve_on,
    input wire logic [1:0]                   o_regulation_state,
    input wire logic                         o_manual_active
);

    // A result held under backpressure keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_raise_valve_on)
            && $stable(o_lower_valve_on) && $stable(o_regulation_state)
            && $stable(o_manual_active))
        else $error("result changed while stalled");

    // The first cycle after reset shows no result.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Input backpressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // The regulation state never takes the unused encoding.
    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_regulation_state != hpvc_pkg::PH_UNUSED)
        else $error("regulation state out of range");

endmodule

bind hysteresis_pulsed_valve_controller_top hpvc_checker u_hpvc_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

// Self-checking bench for the hysteresis pulsed valve controller.
// Every input transfer is run through a local model of the controller at the
// moment it is accepted, and the predicted relay and regulation status is queued.
// The result side pops that queue on every accepted result transfer and compares
// the four fields one by one. Both channels idle at random, with some stretches of
// full-rate traffic, and the registers are only rewritten once the block has
// delivered every queued result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hpvc_pkg::*;

    localparam int LevelMax = (1 << LevelW) - 1;
    localparam logic [CfgW-1:0] CfgMax = {CfgW{1'b1}};
    // Spare cycles waited after the queue empties, to cover a late result.
    localparam int SettleCycles = 4;

    // One tick as it travels on the input channel.
    typedef struct packed {
        logic [LevelW-1:0] level;
        logic              pump;
        logic              fault;
        logic              manual;
        logic [CmdW-1:0]   raise_cmd;
        logic [CmdW-1:0]   lower_cmd;
    } tick_t;

    // The status the block reports after one tick.
    typedef struct packed {
        logic       raise_on;
        logic       lower_on;
        t_reg_phase state;
        logic       manual_on;
    } valve_status_t;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index      = CFG_LOWER_LIMIT;
    logic [CfgW-1:0]     i_cfg_data       = '0;
    logic                i_in_valid       = 1'b0;
    logic [LevelW-1:0]   i_level_ppm      = '0;
    logic                i_pump_on        = 1'b0;
    logic                i_sensor_fault   = 1'b0;
    logic                i_manual_request = 1'b0;
    logic [CmdW-1:0]     i_raise_valve_cmd = CMD_OFF;
    logic [CmdW-1:0]     i_lower_valve_cmd = CMD_OFF;
    logic                i_out_ready      = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_raise_valve_on;
    logic                o_lower_valve_on;
    logic [1:0]          o_regulation_state;
    logic                o_manual_active;

    hysteresis_pulsed_valve_controller_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_level_ppm        (i_level_ppm),
        .i_pump_on          (i_pump_on),
        .i_sensor_fault     (i_sensor_fault),
        .i_manual_request   (i_manual_request),
        .i_raise_valve_cmd  (i_raise_valve_cmd),
        .i_lower_valve_cmd  (i_lower_valve_cmd),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_raise_valve_on   (o_raise_valve_on),
        .o_lower_valve_on   (o_lower_valve_on),
        .o_regulation_state (o_regulation_state),
        .o_manual_active    (o_manual_active)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Statuses predicted for accepted ticks whose result has not arrived yet.
    valve_status_t expected_status[$];
    int unsigned   mismatches;
    // While set, neither side inserts idle cycles.
    bit            steady_flow;

    // Local copy of the registers.
    logic [CfgW-1:0] cfg_lower, cfg_upper, cfg_hyst, cfg_open, cfg_close;

    // Local copy of the controller state.
    bit              in_manual;
    t_reg_phase      phase_now;
    bit              valve_is_open;
    logic [CfgW-1:0] pulse_left;
    bit              pulse_armed;
    bit              pulse_pending;
    bit              relay_raise;
    bit              relay_lower;

    function automatic void reset_controller_model();
        cfg_lower     = RST_LOWER_LIMIT;
        cfg_upper     = RST_UPPER_LIMIT;
        cfg_hyst      = RST_HYSTERESIS_WIDTH;
        cfg_open      = RST_OPEN_TICKS;
        cfg_close     = RST_CLOSE_TICKS;
        in_manual     = 1'b0;
        phase_now     = PH_IN_RANGE;
        valve_is_open = 1'b0;
        pulse_left    = '0;
        pulse_armed   = 1'b0;
        pulse_pending = 1'b0;
        relay_raise   = 1'b0;
        relay_lower   = 1'b0;
    endfunction

    // Closing a valve also kills any pulse timing in progress.
    function automatic void close_valve(input bit lower_side);
        valve_is_open = 1'b0;
        pulse_armed   = 1'b0;
        pulse_left    = '0;
        pulse_pending = 1'b0;
        if (lower_side) relay_lower = 1'b0;
        else relay_raise = 1'b0;
    endfunction

    // A due pulse toggles the valve and reloads the timer for the new half period.
    // A time of zero behaves like one tick since the countdown stops at one or less.
    function automatic void pulse_valve(input bit lower_side);
        if (!pulse_pending) return;
        pulse_pending = 1'b0;
        pulse_armed   = 1'b1;
        pulse_left    = valve_is_open ? cfg_close : cfg_open;
        valve_is_open = !valve_is_open;
        if (lower_side) relay_lower = valve_is_open;
        else relay_raise = valve_is_open;
    endfunction

    // All comparisons are done on doubled values so half the window is exact.
    function automatic void regulate_level(input bit enter_manual, input int level2,
                                           input bit pump, input bit fault);
        int low2   = 2 * int'(cfg_lower);
        int high2  = 2 * int'(cfg_upper);
        int window = int'(cfg_hyst);
        if (enter_manual) begin
            phase_now = PH_IN_RANGE;
            close_valve(1'b0);
            close_valve(1'b1);
        end
        case (phase_now)
            PH_LOW: begin
                if (level2 > low2 + window || !pump || fault) begin
                    phase_now = PH_IN_RANGE;
                    close_valve(1'b0);
                end else begin
                    pulse_valve(1'b0);
                end
            end
            PH_HIGH: begin
                if (level2 < high2 - window || !pump || fault) begin
                    phase_now = PH_IN_RANGE;
                    close_valve(1'b1);
                end else begin
                    pulse_valve(1'b1);
                end
            end
            default: begin
                // Entry tests run even on the tick that enters manual mode.
                // When both hold, the high side wins.
                phase_now = PH_IN_RANGE;
                if (level2 < low2 - window && pump && !fault) begin
                    pulse_pending = 1'b1;
                    phase_now = PH_LOW;
                end
                if (level2 > high2 + window && pump && !fault) begin
                    pulse_pending = 1'b1;
                    phase_now = PH_HIGH;
                end
            end
        endcase
    endfunction

    function automatic valve_status_t predict_tick(input tick_t t);
        valve_status_t s;
        // The pulse timer advances before anything else on each tick.
        if (pulse_armed) begin
            if (pulse_left <= 1) begin
                pulse_left    = '0;
                pulse_armed   = 1'b0;
                pulse_pending = 1'b1;
            end else begin
                pulse_left = pulse_left - 1'b1;
            end
        end
        if (!in_manual) begin
            if (t.manual) in_manual = 1'b1;
            regulate_level(t.manual, 2 * int'(t.level), t.pump, t.fault);
        end else if (!t.manual) begin
            // Leaving manual only changes the mode; the relays keep their values.
            in_manual = 1'b0;
        end else begin
            if (t.raise_cmd == CMD_OFF) relay_raise = 1'b0;
            else if (t.raise_cmd == CMD_ON) relay_raise = 1'b1;
            if (t.lower_cmd == CMD_OFF) relay_lower = 1'b0;
            else if (t.lower_cmd == CMD_ON) relay_lower = 1'b1;
        end
        s.raise_on  = relay_raise;
        s.lower_on  = relay_lower;
        s.state     = phase_now;
        s.manual_on = in_manual;
        return s;
    endfunction

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic tick_t mk_tick(input int level, input bit pump, input bit fault,
                                      input bit manual, input logic [CmdW-1:0] raise_cmd,
                                      input logic [CmdW-1:0] lower_cmd);
        tick_t t;
        t.level     = LevelW'(level);
        t.pump      = pump;
        t.fault     = fault;
        t.manual    = manual;
        t.raise_cmd = raise_cmd;
        t.lower_cmd = lower_cmd;
        return t;
    endfunction

    function automatic tick_t random_tick();
        return mk_tick(int'($urandom_range(0, LevelMax)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       CmdW'($urandom_range(0, 3)), CmdW'($urandom_range(0, 3)));
    endfunction

    // A level a few ppm around a point of interest, clamped to the field range.
    function automatic logic [LevelW-1:0] near_level(input int center);
        int v;
        v = center + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > LevelMax) v = LevelMax;
        return LevelW'(v);
    endfunction

    // Points of interest: clearly outside either window, mid range, on a window edge, or anywhere.
    function automatic int region_center();
        int half = int'(cfg_hyst) / 2;
        case ($urandom_range(0, 7))
            0: return int'(cfg_lower) - half - 6;
            1: return int'(cfg_upper) + half + 6;
            2: return (int'(cfg_lower) + int'(cfg_upper)) / 2;
            3: return int'(cfg_lower) - half;
            4: return int'(cfg_lower) + half;
            5: return int'(cfg_upper) - half;
            6: return int'(cfg_upper) + half;
            default: return $urandom_range(0, LevelMax);
        endcase
    endfunction

    // Must be entered just after i_clk rises. The item is predicted at its transfer.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_level_ppm       <= t.level;
        i_pump_on         <= t.pump;
        i_sensor_fault    <= t.fault;
        i_manual_request  <= t.manual;
        i_raise_valve_cmd <= t.raise_cmd;
        i_lower_valve_cmd <= t.lower_cmd;
        do @(posedge i_clk); while (!o_in_ready);
        expected_status.push_back(predict_tick(t));
    endtask

    // The enable is lowered after each write before the next one, so that it is never dropped and raised in one step.
    task automatic write_register(input logic [CfgIdxW-1:0] index,
                                  input logic [CfgW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_LOWER_LIMIT:      cfg_lower = value;
            CFG_UPPER_LIMIT:      cfg_upper = value;
            CFG_HYSTERESIS_WIDTH: cfg_hyst  = value;
            CFG_OPEN_TICKS:       cfg_open  = value;
            CFG_CLOSE_TICKS:      cfg_close = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_registers(input logic [CfgW-1:0] lower, input logic [CfgW-1:0] upper,
                                       input logic [CfgW-1:0] hyst, input logic [CfgW-1:0] open_t,
                                       input logic [CfgW-1:0] close_t);
        write_register(CFG_LOWER_LIMIT, lower);
        write_register(CFG_UPPER_LIMIT, upper);
        write_register(CFG_HYSTERESIS_WIDTH, hyst);
        write_register(CFG_OPEN_TICKS, open_t);
        write_register(CFG_CLOSE_TICKS, close_t);
    endtask

    // Stop sending and let every queued result come back before touching registers.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Well-formed regulation traffic: runs of ticks that hold the level near one
    // point of interest with the pump mostly on, bursts of manual operation, and
    // some fully random ticks in between.
    task automatic run_regulation(input int count);
        int    left;
        int    run_len;
        int    center;
        int    k;
        int    choice;
        tick_t t;
        left = count;
        while (left > 0) begin
            choice = $urandom_range(0, 99);
            if (choice < 15) begin
                send_tick(random_tick());
                left--;
            end else if (choice < 30) begin
                run_len = $urandom_range(1, 6);
                for (k = 0; k < run_len && left > 0; k++) begin
                    t = random_tick();
                    t.manual = 1'b1;
                    send_tick(t);
                    left--;
                end
            end else begin
                center  = region_center();
                run_len = $urandom_range(2, 25);
                for (k = 0; k < run_len && left > 0; k++) begin
                    t = random_tick();
                    t.level  = near_level(center);
                    t.pump   = ($urandom_range(0, 19) != 0);
                    t.fault  = ($urandom_range(0, 24) == 0);
                    t.manual = 1'b0;
                    send_tick(t);
                    left--;
                end
            end
        end
    endtask

    // Field extremes and every entry and exit path under the reset limits
    // (low window edge 150, high window edge 1050, exit edges 250 and 950).
    task automatic test_field_extremes();
        send_tick(mk_tick(0, 1'b0, 1'b0, 1'b0, CMD_OFF, CMD_OFF));     // pump off blocks entry
        send_tick(mk_tick(0, 1'b1, 1'b1, 1'b0, CMD_ON, CMD_ON));       // fault blocks entry
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, 2'd3, 2'd3));           // enter low
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));     // raise valve opens
        send_tick(mk_tick(250, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // on the exit edge, stays
        send_tick(mk_tick(251, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // past it, exits
        send_tick(mk_tick(LevelMax, 1'b1, 1'b0, 1'b0, 2'd2, 2'd2));    // enter high
        send_tick(mk_tick(LevelMax, 1'b1, 1'b1, 1'b0, CMD_OFF, CMD_OFF)); // fault exits
        send_tick(mk_tick(LevelMax, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF)); // enter high again
        send_tick(mk_tick(LevelMax, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF)); // lower valve opens
        send_tick(mk_tick(LevelMax, 1'b0, 1'b0, 1'b0, CMD_OFF, CMD_OFF)); // pump off exits
        send_tick(mk_tick(150, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // on the entry edge
        send_tick(mk_tick(149, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // enters low
        send_tick(mk_tick(1050, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));  // level exits low
        send_tick(mk_tick(1051, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));  // enters high
        send_tick(mk_tick(950, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // on the exit edge
        send_tick(mk_tick(949, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));   // exits high
    endtask

    // Manual entry while regulating, every valve command code, and the return.
    task automatic test_manual_override();
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));     // enter low
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));     // raise valve opens
        // Entering manual closes the valves, but the entry test shows low again.
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b1, CMD_ON, CMD_ON));
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b1, CMD_ON, CMD_ON));
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b1, CMD_OFF, 2'd2));
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b1, 2'd3, CMD_OFF));
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b1, 2'd2, CMD_ON));
        // Leaving manual keeps the relays; regulation resumes from the low state.
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));
        send_tick(mk_tick(0, 1'b1, 1'b0, 1'b0, CMD_OFF, CMD_OFF));
    endtask

    // Short open and close times so that whole pulse trains fit in a few ticks.
    task automatic test_pulse_train();
        write_all_registers(16'd300, 16'd700, 16'd40, 16'd3, 16'd2);
        run_regulation(60);
        wait_for_results();
    endtask

    // Register extremes: crossed limits where both entry tests hold and high wins,
    // zero times, an unreachable window, and the longest open time.
    task automatic test_register_extremes();
        write_all_registers(CfgMax, '0, '0, '0, '0);
        run_regulation(30);
        wait_for_results();
        write_all_registers('0, CfgMax, CfgMax, CfgMax, CfgMax);
        run_regulation(30);
        wait_for_results();
        write_all_registers(16'd1000, 16'd2000, '0, CfgMax, 16'd1);
        run_regulation(30);
        wait_for_results();
    endtask

    // Random limits and times, one full-rate phase among them.
    task automatic test_random_settings();
        int p;
        logic [CfgW-1:0] lower;
        logic [CfgW-1:0] upper;
        for (p = 0; p < 6; p++) begin
            lower = CfgW'($urandom_range(0, 3000));
            if ($urandom_range(0, 9) == 0)
                upper = CfgW'($urandom_range(0, 3000));
            else
                upper = lower + CfgW'($urandom_range(0, 3000));
            write_all_registers(lower, upper, CfgW'($urandom_range(0, 400)),
                                CfgW'($urandom_range(1, 6)), CfgW'($urandom_range(1, 6)));
            steady_flow = (p == 2);
            run_regulation(45);
            wait_for_results();
            steady_flow = 1'b0;
        end
    endtask

    // Result side back-pressure: ready drops for random stretches.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge i_clk);
        end
    end

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Each result transfer is held against the oldest prediction, field by field.
    always @(posedge i_clk) begin
        valve_status_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: result transfer with no tick pending", $time);
            end else begin
                want = expected_status.pop_front();
                if (o_raise_valve_on !== want.raise_on)
                    note_mismatch("raise valve", want.raise_on, o_raise_valve_on);
                if (o_lower_valve_on !== want.lower_on)
                    note_mismatch("lower valve", want.lower_on, o_lower_valve_on);
                if (o_regulation_state !== want.state)
                    note_mismatch("regulation state", want.state, o_regulation_state);
                if (o_manual_active !== want.manual_on)
                    note_mismatch("manual mode", want.manual_on, o_manual_active);
            end
        end
    end

    // Timeout set far beyond the slowest legitimate run.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        mismatches  = 0;
        steady_flow = 1'b0;
        reset_controller_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_manual_override();
        wait_for_results();
        test_pulse_train();
        test_register_extremes();
        test_random_settings();

        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
